### rtl/circ_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circ_pkg
// Shared widths, codes and the point word passed from front to back.
// ----------------------------------------------------------------------------
package circ_pkg;

  // default width of the radius and offset datapath
  localparam int RadiusBitsDef = 12;

  // fixed field widths
  localparam int CoordW  = 13;
  localparam int RadInW  = 12;
  localparam int ColorW  = 8;
  localparam int PixW    = 14;
  localparam int NumPix  = 8;
  localparam int PixCntW = $clog2(NumPix);

  // item codes
  localparam logic FuncStart = 1'b0;
  localparam logic FuncStep  = 1'b1;

  // one point of the circle, offsets already reduced to pixel width
  typedef struct packed {
    logic signed [PixW-1:0]   cx;
    logic signed [PixW-1:0]   cy;
    logic signed [PixW-1:0]   ox;
    logic signed [PixW-1:0]   oy;
    logic [ColorW-1:0]        red;
    logic [ColorW-1:0]        green;
    logic [ColorW-1:0]        blue;
    logic [ColorW-1:0]        alpha;
    logic                     fin;
  } job_t;

endpackage

### rtl/circ_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circ_in_if
// Input channel: start or step words with center, radius and color.
// ----------------------------------------------------------------------------
interface circ_in_if import circ_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic [RadInW-1:0]        radius_in;
  logic [ColorW-1:0]        red_in;
  logic [ColorW-1:0]        green_in;
  logic [ColorW-1:0]        blue_in;
  logic [ColorW-1:0]        alpha_in;

  modport source (
    output valid, func, center_x, center_y, radius_in,
           red_in, green_in, blue_in, alpha_in,
    input  ready
  );

  modport sink (
    input  valid, func, center_x, center_y, radius_in,
           red_in, green_in, blue_in, alpha_in,
    output ready
  );

endinterface

### rtl/circ_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circ_out_if
// Output channel: one pixel word per handshake.
// ----------------------------------------------------------------------------
interface circ_out_if import circ_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic signed [PixW-1:0] pixel_x;
  logic signed [PixW-1:0] pixel_y;
  logic [ColorW-1:0]      pixel_red;
  logic [ColorW-1:0]      pixel_green;
  logic [ColorW-1:0]      pixel_blue;
  logic [ColorW-1:0]      pixel_alpha;
  logic                   circle_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           pixel_alpha, circle_done,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           pixel_alpha, circle_done,
    output ready
  );

endinterface

### rtl/circ_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circ_front
// Accepts start and step words, keeps the circle state and runs one step
// of the error rule per word, handing the current point to the queue.
// ----------------------------------------------------------------------------
module circ_front import circ_pkg::*; #(
  parameter int RADIUS_BITS = RadiusBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  circ_in_if.sink    in_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output job_t       push_job_o
);

  localparam int OffW = RADIUS_BITS + 1;  // signed offsets, y may reach -1
  localparam int ErrW = RADIUS_BITS + 3;  // stored error term
  localparam int CalW = RADIUS_BITS + 4;  // headroom for 2x terms

  logic signed [OffW-1:0]   off_x_q, off_x_d;
  logic signed [OffW-1:0]   off_y_q, off_y_d;
  logic signed [ErrW-1:0]   err_q, err_d;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic [RADIUS_BITS-1:0]   rad_q;
  logic [ColorW-1:0]        red_q, green_q, blue_q, alpha_q;
  logic                     active_q;

  logic                     is_start;
  logic                     accept;
  logic                     emit;
  logic [31:0]              rad_ext;
  logic [RADIUS_BITS-1:0]   rad_new;
  logic [RADIUS_BITS-1:0]   rad_cur;
  logic signed [CalW-1:0]   x_w, y_w, e_w, r_w;
  logic signed [CalW-1:0]   x_n, y_n, e_n;
  logic                     fin;
  logic signed [31:0]       ox_ext, oy_ext;
  logic signed [CoordW-1:0] cx_cur, cy_cur;
  logic [ColorW-1:0]        red_cur, green_cur, blue_cur, alpha_cur;

  // handshake
  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid & push_ready_i;
  assign is_start   = (in_i.func == FuncStart);
  assign emit       = accept & (is_start | active_q);

  // radius limited to the datapath width
  assign rad_ext = 32'(in_i.radius_in);
  assign rad_new = rad_ext[RADIUS_BITS-1:0];

  // operands: fresh circle on start, stored state otherwise
  always_comb begin
    if (is_start) begin
      rad_cur   = rad_new;
      x_w       = '0;
      y_w       = CalW'(rad_new);
      e_w       = CalW'(rad_new) - CalW'(1);
      cx_cur    = in_i.center_x;
      cy_cur    = in_i.center_y;
      red_cur   = in_i.red_in;
      green_cur = in_i.green_in;
      blue_cur  = in_i.blue_in;
      alpha_cur = in_i.alpha_in;
    end else begin
      rad_cur   = rad_q;
      x_w       = CalW'(off_x_q);
      y_w       = CalW'(off_y_q);
      e_w       = CalW'(err_q);
      cx_cur    = cx_q;
      cy_cur    = cy_q;
      red_cur   = red_q;
      green_cur = green_q;
      blue_cur  = blue_q;
      alpha_cur = alpha_q;
    end
    r_w = CalW'(rad_cur);
  end

  // one step of the error rule
  always_comb begin
    if (e_w >= (x_w <<< 1)) begin
      e_n = e_w - (x_w <<< 1) - CalW'(1);
      x_n = x_w + CalW'(1);
      y_n = y_w;
    end else if (e_w < ((r_w - y_w) <<< 1)) begin
      e_n = e_w + (y_w <<< 1) - CalW'(1);
      x_n = x_w;
      y_n = y_w - CalW'(1);
    end else begin
      e_n = e_w + ((y_w - x_w - CalW'(1)) <<< 1);
      x_n = x_w + CalW'(1);
      y_n = y_w - CalW'(1);
    end
    fin     = (y_n < x_n);
    off_x_d = x_n[OffW-1:0];
    off_y_d = y_n[OffW-1:0];
    err_d   = e_n[ErrW-1:0];
  end

  // point word for the back end, offsets reduced to pixel width
  assign ox_ext = 32'(x_w);
  assign oy_ext = 32'(y_w);

  always_comb begin
    push_job_o.cx    = PixW'(cx_cur);
    push_job_o.cy    = PixW'(cy_cur);
    push_job_o.ox    = ox_ext[PixW-1:0];
    push_job_o.oy    = oy_ext[PixW-1:0];
    push_job_o.red   = red_cur;
    push_job_o.green = green_cur;
    push_job_o.blue  = blue_cur;
    push_job_o.alpha = alpha_cur;
    push_job_o.fin   = fin;
  end

  assign push_valid_o = in_i.valid & (is_start | active_q);

  // circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q  <= '0;
      off_y_q  <= '0;
      err_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      rad_q    <= '0;
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      alpha_q  <= '0;
      active_q <= 1'b0;
    end else if (emit) begin
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
      err_q    <= err_d;
      active_q <= ~fin;
      if (is_start) begin
        cx_q    <= in_i.center_x;
        cy_q    <= in_i.center_y;
        rad_q   <= rad_new;
        red_q   <= in_i.red_in;
        green_q <= in_i.green_in;
        blue_q  <= in_i.blue_in;
        alpha_q <= in_i.alpha_in;
      end
    end
  end

endmodule

### rtl/circ_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circ_queue
// Two-entry queue of point words between front and back.
// ----------------------------------------------------------------------------
module circ_queue import circ_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_job_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  // fill count
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### rtl/circ_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circ_back
// Expands one point word into its eight mirrored pixels, one per cycle while
// the output accepts them, through a registered output stage.
// ----------------------------------------------------------------------------
module circ_back import circ_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  job_t       pop_job_i,
  circ_out_if.source out_o
);

  localparam logic [PixCntW-1:0] LastPix = PixCntW'(NumPix - 1);

  job_t                   job_q;
  logic                   busy_q, busy_d;
  logic [PixCntW-1:0]     idx_q, idx_d;
  logic                   out_vld_q;
  logic signed [PixW-1:0] px_q, py_q, px_d, py_d;
  logic [ColorW-1:0]      red_q, green_q, blue_q, alpha_q;
  logic                   done_q;

  logic                   load_out;
  logic                   take_job;
  logic                   last;
  logic signed [PixW-1:0] a, b;

  assign load_out    = busy_q & (~out_vld_q | out_o.ready);
  assign last        = (idx_q == LastPix);
  assign pop_ready_o = ~busy_q | (load_out & last);
  assign take_job    = pop_valid_i & pop_ready_o;

  // mirror selection: bit 2 swaps axes, bit 0 negates x, bit 1 negates y
  always_comb begin
    a    = idx_q[2] ? job_q.oy : job_q.ox;
    b    = idx_q[2] ? job_q.ox : job_q.oy;
    px_d = idx_q[0] ? (job_q.cx - a) : (job_q.cx + a);
    py_d = idx_q[1] ? (job_q.cy - b) : (job_q.cy + b);
  end

  // sequencing over the eight pixels
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_out) begin
      idx_d = idx_q + PixCntW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (take_job) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // point word and output payload
  always_ff @(posedge clk_i) begin
    if (take_job) begin
      job_q <= pop_job_i;
    end
    if (load_out) begin
      px_q    <= px_d;
      py_q    <= py_d;
      red_q   <= job_q.red;
      green_q <= job_q.green;
      blue_q  <= job_q.blue;
      alpha_q <= job_q.alpha;
      done_q  <= job_q.fin & last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.pixel_red   = red_q;
  assign out_o.pixel_green = green_q;
  assign out_o.pixel_blue  = blue_q;
  assign out_o.pixel_alpha = alpha_q;
  assign out_o.circle_done = done_q;

endmodule

### rtl/circle_outline_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_outline_rasterizer
// Circle outline rasterizer: error-rule stepping with eight-way mirroring.
// ----------------------------------------------------------------------------
// A start word (func 0) loads center, radius and color and yields the eight
// mirrored pixels of point (0, radius); each step word (func 1) yields the
// eight pixels of the next point. A step word with no circle in progress is
// taken as soon as the point queue has room and yields nothing. Every other
// word yields eight pixel words, one per cycle on the single output port while
// out_o.ready holds; a two-entry point queue lets the front take new words
// while the back is still writing pixels. circle_done marks the last pixel
// of a circle. Coordinates wrap to 14 bits and are not clipped.
module circle_outline_rasterizer import circ_pkg::*; #(
  parameter int RADIUS_BITS = RadiusBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  circ_in_if.sink    in_i,
  circ_out_if.source out_o
);

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  // word intake and stepping
  circ_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // point queue
  circ_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // pixel expansion
  circ_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

endmodule
